// ----- rtl/pcs_pkg.sv -----
// Package for the packed Cholesky solver: function codes, status codes,
// sequencer states. No dependencies.
package pcs_pkg;

    localparam logic [1:0] FUNC_LOAD_L   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B   = 2'd1;
    localparam logic [1:0] FUNC_START    = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_PIVOT = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_DRD,
        ST_DIV,
        ST_WB,
        ST_ORD,
        ST_OUT
    } seq_state_t;

endpackage

// ----- rtl/pcs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/packed_cholesky_solve.sv -----
// Top level of the packed Cholesky solver.
// Depends on pcs_pkg and pcs_ram.
//
// Solves L*L'*x = b in signed fixed point with FRAC_BITS fraction bits. Factor
// words (func 0, packed row by row) and right-hand-side words (func 1) load one
// per cycle. A start (func 2) runs forward then backward substitution in place
// and emits x[0..n-1] with tlast on the final element. A solve makes 2*n row
// updates. Each multiply-accumulate walks read, multiply, accumulate through the
// single read port of each memory. Each row update passes set-up, reads and
// write-back around a restoring divider, one quotient bit per cycle. No items
// are taken while a solve runs or its results drain.
module packed_cholesky_solve #(
    parameter int MAX_DIM   = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: dimension
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [1:0] func, [9:2] index, [41:10] value, zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] out_index, [35:4] solution, zero pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] status
);
    import pcs_pkg::*;

    localparam int FDEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int VAW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW     = $clog2(MAX_DIM + 1);
    localparam int NUMW   = 32 + FRAC_BITS;   // dividend magnitude width
    localparam int QW     = NUMW;
    localparam int DCW    = $clog2(QW + 1);
    localparam int ACCW   = 40;
    localparam logic signed [ACCW-1:0] MAXV = ACCW'(64'sd2147483647);
    localparam logic signed [ACCW-1:0] MINV = -ACCW'(64'sd2147483648);

    // Input fields
    logic [1:0]         in_func;
    logic [7:0]         in_index;
    logic signed [31:0] in_value;
    assign in_func  = s_tdata[1:0];
    assign in_index = s_tdata[9:2];
    assign in_value = s_tdata[41:10];

    seq_state_t state_reg, state_next;
    logic [4:0]       dim_reg;
    logic [CW-1:0]    n_reg;
    logic             back_reg;
    logic [CW-1:0]    i_reg, j_reg;
    logic [FAW-1:0]   rowbase_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] a_reg;
    logic             sat_reg, piv_reg;
    logic [QW-1:0]    rem_reg, quo_reg, dvd_reg;
    logic [32:0]      dvs_reg;
    logic             qneg_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [31:0]      x_reg;
    logic [CW-1:0]    oi_reg;
    logic             ovalid_reg;
    logic [CW-1:0]    m_idx_reg;
    logic             seed_reg;

    // Memories
    logic            f_we, v_we;
    logic [FAW-1:0]  f_waddr, f_raddr;
    logic [VAW-1:0]  v_waddr, v_raddr;
    logic [31:0]     f_wdata, v_wdata, f_rdata, v_rdata;

    pcs_ram #(.WIDTH(32), .DEPTH(FDEPTH)) u_factor (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    pcs_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_vector (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    logic s_fire, m_fire, out_load;
    assign s_tready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    // Load the output register when it is empty or its transfer completes
    assign out_load  = (state_reg == ST_OUT) && (m_fire || !ovalid_reg);

    // Packed addresses: row j base for the backward multiply step, and the diagonal
    logic [FAW-1:0] rowbase_j;   // base of row j, for backward pass
    logic [FAW-1:0] diag_addr;
    always_comb begin
        rowbase_j = FAW'((32'(j_reg) * (32'(j_reg) + 32'd1)) >> 1);
        diag_addr = rowbase_reg + FAW'(i_reg);
    end

    // Rounded product, saturated
    logic signed [63:0] prnd;
    logic signed [63:0] pq;
    logic               psat;
    logic signed [31:0] pval;
    always_comb begin
        prnd = prod_reg + ((64'sd1 <<< FRAC_BITS) >>> 1);
        pq   = prnd >>> FRAC_BITS;
        psat = (pq > 64'sd2147483647) || (pq < -64'sd2147483648);
        if (pq > 64'sd2147483647) begin
            pval = 32'h7fffffff;
        end else if (pq < -64'sd2147483648) begin
            pval = 32'h80000000;
        end else begin
            pval = pq[31:0];
        end
    end

    // Saturated accumulator, dividend magnitude
    logic signed [31:0] accs;
    logic               asat;
    logic [32:0]        amag;
    always_comb begin
        asat = (acc_reg > MAXV) || (acc_reg < MINV);
        if (acc_reg > MAXV) begin
            accs = 32'h7fffffff;
        end else if (acc_reg < MINV) begin
            accs = 32'h80000000;
        end else begin
            accs = acc_reg[31:0];
        end
        amag = accs[31] ? 33'(-34'(signed'(accs))) : {1'b0, accs};
    end

    // Divider step and final quotient; a zero divisor gives zero
    logic [QW:0]   trial;
    logic [QW-1:0] rem_sh;
    logic [QW:0]   qsigned_mag;
    logic signed [QW+1:0] qfin;
    logic          qsat;
    logic [31:0]   qval;
    always_comb begin
        rem_sh = {rem_reg[QW-2:0], dvd_reg[QW-1]};
        trial  = {1'b0, rem_sh} - (QW+1)'(dvs_reg);
        qsigned_mag = {1'b0, quo_reg};
        qfin = qneg_reg ? -(QW+2)'(qsigned_mag) : (QW+2)'(qsigned_mag);
        qsat = (qfin > (QW+2)'(64'sd2147483647)) || (qfin < -(QW+2)'(64'sd2147483648));
        if (dvs_reg == '0) begin
            qval = 32'h0;
        end else if (qfin > (QW+2)'(64'sd2147483647)) begin
            qval = 32'h7fffffff;
        end else if (qfin < -(QW+2)'(64'sd2147483648)) begin
            qval = 32'h80000000;
        end else begin
            qval = qfin[31:0];
        end
    end

    logic [CW-1:0] n_eff;
    always_comb begin
        if (dim_reg == 5'd0) begin
            n_eff = CW'(1);
        end else if (32'(dim_reg) > MAX_DIM) begin
            n_eff = CW'(MAX_DIM);
        end else begin
            n_eff = CW'(dim_reg);
        end
    end

    // Whether the current row has more products
    logic more_terms;
    always_comb begin
        more_terms = back_reg ? (j_reg < n_reg) : (j_reg < i_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire && in_func == FUNC_START) state_next = ST_ROW;
            ST_ROW:  state_next = ST_RD;
            ST_RD:   state_next = more_terms ? ST_MUL : ST_DRD;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_RD;
            ST_DRD:  state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == DCW'(QW)) state_next = ST_WB;
            ST_WB: begin
                if (!back_reg) begin
                    state_next = ST_ROW;
                end else begin
                    state_next = (i_reg == CW'(0)) ? ST_ORD : ST_ROW;
                end
            end
            ST_ORD:  state_next = ST_OUT;
            ST_OUT:  if (out_load && (oi_reg + CW'(1) == n_reg)) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        f_we    = s_fire && in_func == FUNC_LOAD_L && 32'(in_index) < FDEPTH;
        f_waddr = FAW'(in_index);
        f_wdata = in_value;
        v_we    = (s_fire && in_func == FUNC_LOAD_B && 32'(in_index) < MAX_DIM)
                  || state_reg == ST_WB;
        v_waddr = (state_reg == ST_WB) ? VAW'(i_reg) : VAW'(in_index);
        v_wdata = (state_reg == ST_WB) ? qval : in_value;
        f_raddr = diag_addr;
        v_raddr = VAW'(i_reg);
        if (state_reg == ST_RD && more_terms) begin
            f_raddr = back_reg ? FAW'(rowbase_j + FAW'(i_reg))
                               : FAW'(rowbase_reg + FAW'(j_reg));
            v_raddr = VAW'(j_reg);
        end else if (state_reg == ST_ROW) begin
            v_raddr = VAW'(i_reg);
        end else if (state_reg == ST_ORD) begin
            v_raddr = '0;
        end else if (state_reg == ST_OUT) begin
            // read ahead of a load so the next element is ready in the following cycle
            v_raddr = out_load ? VAW'(oi_reg + CW'(1)) : VAW'(oi_reg);
        end
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dim_reg    <= 5'd1;
            ovalid_reg <= 1'b0;
            sat_reg    <= 1'b0;
            piv_reg    <= 1'b0;
            dcnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) dim_reg <= cfg_data;
            unique case (state_reg)
                ST_IDLE: if (s_fire && in_func == FUNC_START) begin
                    n_reg       <= n_eff;
                    back_reg    <= 1'b0;
                    i_reg       <= '0;
                    rowbase_reg <= '0;
                    sat_reg     <= 1'b0;
                    piv_reg     <= 1'b0;
                    dcnt_reg    <= '0;
                end
                ST_ROW: begin
                    j_reg <= back_reg ? i_reg + CW'(1) : '0;
                end
                ST_RD: begin
                    // first pass through RD loads vector entry i (b[i] forward, y[i] backward) into the accumulator
                    if (seed_reg) acc_reg <= ACCW'(signed'(v_rdata));
                end
                ST_MUL: begin
                    prod_reg <= 64'(signed'(f_rdata)) * 64'(signed'(v_rdata));
                end
                ST_ACC: begin
                    acc_reg <= acc_reg - ACCW'(pval);
                    if (psat) sat_reg <= 1'b1;
                    j_reg <= j_reg + CW'(1);
                end
                ST_DRD: ;
                ST_DIV: begin
                    if (dcnt_reg == '0) begin
                        if (asat) sat_reg <= 1'b1;
                        dvd_reg  <= QW'(amag) << FRAC_BITS;
                        dvs_reg  <= f_rdata[31] ? 33'(-34'(signed'(f_rdata)))
                                                : {1'b0, f_rdata};
                        qneg_reg <= accs[31] ^ f_rdata[31];
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        dcnt_reg <= DCW'(1);
                        if (f_rdata == 32'd0) piv_reg <= 1'b1;
                    end else begin
                        dvd_reg  <= dvd_reg << 1;
                        if (!trial[QW]) begin
                            rem_reg <= trial[QW-1:0];
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg + DCW'(1);
                    end
                end
                ST_WB: begin
                    dcnt_reg <= '0;
                    if (dvs_reg != '0 && qsat) sat_reg <= 1'b1;
                    if (!back_reg) begin
                        if (i_reg + CW'(1) == n_reg) begin
                            back_reg <= 1'b1;
                        end else begin
                            rowbase_reg <= rowbase_reg + FAW'(i_reg) + FAW'(1);
                            i_reg       <= i_reg + CW'(1);
                        end
                    end else if (i_reg != '0) begin
                        rowbase_reg <= rowbase_reg - FAW'(i_reg);
                        i_reg       <= i_reg - CW'(1);
                    end
                end
                ST_ORD: begin
                    oi_reg <= '0;
                end
                ST_OUT: begin
                    if (out_load) oi_reg <= oi_reg + CW'(1);
                end
                default: ;
            endcase
            // Output register: hold until transfer, load next element
            if (out_load) begin
                ovalid_reg <= 1'b1;
                x_reg      <= v_rdata;
                m_idx_reg  <= oi_reg;
            end else if (m_fire) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Accumulator seed: the read issued in ROW returns vector entry i during RD
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 1'b0;
        end else begin
            seed_reg <= (state_reg == ST_ROW);
        end
    end

    // Outputs
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, x_reg, 4'(m_idx_reg)};
    assign m_tlast  = (m_idx_reg + CW'(1) == n_reg);
    assign m_tuser  = piv_reg ? STATUS_PIVOT : (sat_reg ? STATUS_SAT : STATUS_OK);

    // Checks
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken during solve");
    a_out_only_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == ST_OUT || state_reg == ST_IDLE))
        else $error("result outside drain");
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_idx_reg < n_reg))
        else $error("result index beyond dimension");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tlast) && $stable(m_tuser)))
        else $error("result changed while waiting");
endmodule

// ----- bench/packed_cholesky_solve_tb.sv -----
// Self-checking bench for packed_cholesky_solve: factor/RHS loads, solves, dimension writes.
// Depends on pcs_pkg and the packed_cholesky_solve RTL; a built-in predictor checks results.
`timescale 1ns / 100ps

module packed_cholesky_solve_tb;
    import pcs_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int DEPTH = 136;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  index;
        logic [31:0] value;
    } load_item_t;

    typedef struct {
        logic [3:0]  index;
        logic [31:0] x;
        logic        last;
        logic [1:0]  status;
    } soln_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    packed_cholesky_solve dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic signed [31:0] factor_mem [DEPTH];
    logic signed [31:0] rhs_vec [16];
    logic [4:0]         dim_reg = 5'd1;
    logic               sat_flag, pivot_flag;

    // stimulus bookkeeping
    load_item_t pending_q [$];
    soln_t      solution_q [$];
    bit         factor_set [DEPTH];
    bit         rhs_set [16];
    bit         hold_sender = 1'b0;
    bit         no_gaps = 1'b0;
    int         fail_count = 0;
    int         solves_run = 0, results_seen = 0, pivot_runs = 0, sat_runs = 0;
    int         stim_count = 0;

    function automatic int tri_base(input int row);
        return row * (row + 1) / 2;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) begin
            sat_flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat_flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clip32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] num,
                                                  input logic signed [31:0] den);
        longint t;
        if (den == 0) begin
            pivot_flag = 1'b1;
            return 32'sd0;
        end
        t = longint'(num) <<< 16;
        return clip32(t / longint'(den));
    endfunction

    // forward then backward substitution, queue one result per element
    task automatic solve_and_expect();
        int n;
        longint acc;
        logic [1:0] st;
        soln_t r;
        n = dim_reg;
        if (n == 0) n = 1;
        if (n > 16) n = 16;
        sat_flag = 1'b0;
        pivot_flag = 1'b0;
        for (int i = 0; i < n; i++) begin
            acc = rhs_vec[i];
            for (int j = 0; j < i; j++)
                acc -= fx_mul(rhs_vec[j], factor_mem[tri_base(i) + j]);
            rhs_vec[i] = fx_div(clip32(acc), factor_mem[tri_base(i) + i]);
        end
        for (int i = n - 1; i >= 0; i--) begin
            acc = rhs_vec[i];
            for (int j = i + 1; j < n; j++)
                acc -= fx_mul(factor_mem[tri_base(j) + i], rhs_vec[j]);
            rhs_vec[i] = fx_div(clip32(acc), factor_mem[tri_base(i) + i]);
        end
        st = pivot_flag ? STATUS_PIVOT : (sat_flag ? STATUS_SAT : STATUS_OK);
        solves_run++;
        if (st == STATUS_PIVOT) pivot_runs++;
        if (st == STATUS_SAT) sat_runs++;
        for (int i = 0; i < n; i++) begin
            r.index = i[3:0];
            r.x = rhs_vec[i];
            r.last = (i == n - 1);
            r.status = st;
            solution_q.push_back(r);
        end
    endtask

    task automatic apply_item(input load_item_t it);
        case (it.func)
            FUNC_LOAD_L: if (it.index < DEPTH) factor_mem[it.index] = it.value;
            FUNC_LOAD_B: if (it.index < 16) rhs_vec[it.index] = it.value;
            FUNC_START:  solve_and_expect();
            default: ;
        endcase
    endtask

    // driver: present queued items, random gap after each transfer unless no_gaps is set
    always @(posedge aclk) begin
        logic nv;
        int gap;
        load_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap = 0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                it.func = s_tdata[1:0];
                it.index = s_tdata[9:2];
                it.value = s_tdata[41:10];
                apply_item(it);
                nv = 1'b0;
                gap = no_gaps ? 0 : $urandom_range(0, 17);
            end
            if (!nv && !hold_sender) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_q.size() > 0) begin
                    it = pending_q.pop_front();
                    s_tdata <= {6'b0, it.value, it.index, it.func};
                    nv = 1'b1;
                end
            end
            s_tvalid <= nv;
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        logic nr;
        int stall;
        soln_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall = 0;
        end else begin
            nr = m_tready;
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (solution_q.size() == 0) begin
                    $display("%0t: unexpected result idx=%0d x=%h", $time,
                             m_tdata[3:0], m_tdata[35:4]);
                    fail_count++;
                end else begin
                    e = solution_q.pop_front();
                    if (m_tdata[3:0] !== e.index || m_tdata[35:4] !== e.x ||
                        m_tlast !== e.last || m_tuser !== e.status ||
                        m_tdata[39:36] !== 4'b0) begin
                        $display("%0t: mismatch exp idx=%0d x=%h last=%b st=%0d",
                                 $time, e.index, e.x, e.last, e.status);
                        $display("%0t:          got idx=%0d x=%h last=%b st=%0d",
                                 $time, m_tdata[3:0], m_tdata[35:4], m_tlast, m_tuser);
                        fail_count++;
                    end
                end
                nr = 1'b0;
                stall = no_gaps ? 0 : $urandom_range(0, 17);
            end
            if (!nr) begin
                if (stall > 0) stall--;
                else nr = 1'b1;
            end
            m_tready <= nr;
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        int idle;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle = 0;
        end else begin
            idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("** packed_cholesky_solve: FAILED **");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [1:0] f, input logic [7:0] idx,
                             input logic [31:0] val);
        load_item_t it;
        it.func = f;
        it.index = idx;
        it.value = val;
        if (f == FUNC_LOAD_L && idx < DEPTH) factor_set[idx] = 1'b1;
        if (f == FUNC_LOAD_B && idx < 16) rhs_set[idx] = 1'b1;
        if (f == FUNC_LOAD_L || f == FUNC_LOAD_B || f == FUNC_START) stim_count++;
        pending_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        if (sel < 8) return $urandom;
        case ($urandom_range(0, 2))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] rand_diag();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 32'h0;
        if (sel == 1) return $urandom;
        if (sel == 2) return 32'($urandom_range(1, 255));
        return 32'($urandom_range(32'h8000, 32'h40000));
    endfunction

    function automatic int eff_dim();
        if (dim_reg == 0) return 1;
        if (dim_reg > 16) return 16;
        return dim_reg;
    endfunction

    // random reloads, some noise, fill anything unset that the solve reads, then start
    task automatic queue_solve();
        int n, cnt, row, col;
        n = eff_dim();
        cnt = $urandom_range(1, (n < 4) ? tri_base(n) + n : 12);
        for (int k = 0; k < cnt; k++) begin
            row = $urandom_range(0, n - 1);
            col = $urandom_range(0, row);
            if ($urandom_range(0, 2) == 0)
                push_item(FUNC_LOAD_B, 8'(row), rand_word());
            else
                push_item(FUNC_LOAD_L, 8'(tri_base(row) + col),
                          (row == col) ? rand_diag() : rand_word());
            if ($urandom_range(0, 9) == 0)
                push_item($urandom_range(0, 3) == 0 ? FUNC_UNUSED : FUNC_LOAD_L,
                          8'($urandom_range(DEPTH, 255)), $urandom);
        end
        for (int r = 0; r < n; r++) begin
            if (!rhs_set[r]) push_item(FUNC_LOAD_B, 8'(r), rand_word());
            for (int c = 0; c <= r; c++)
                if (!factor_set[tri_base(r) + c])
                    push_item(FUNC_LOAD_L, 8'(tri_base(r) + c),
                              (r == c) ? rand_diag() : rand_word());
        end
        push_item(FUNC_START, 8'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_tvalid || solution_q.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_dimension(input logic [4:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        dim_reg = d;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [4:0] dims [$];
        int phase;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: single unknown, pivots, saturation, ignored items
        write_dimension(5'd1);
        push_item(FUNC_LOAD_L, 8'd0, 32'h0001_0000);
        push_item(FUNC_LOAD_B, 8'd0, 32'h0002_0000);
        push_item(FUNC_START, 8'd0, 32'h0);
        push_item(FUNC_START, 8'hff, 32'hffffffff);
        push_item(FUNC_LOAD_L, 8'd0, 32'h0);
        push_item(FUNC_START, 8'd0, 32'h0);
        push_item(FUNC_LOAD_L, 8'd0, 32'h0000_0001);
        push_item(FUNC_LOAD_B, 8'd0, 32'h7fffffff);
        push_item(FUNC_START, 8'd0, 32'h0);
        push_item(FUNC_LOAD_L, 8'd0, 32'h80000000);
        push_item(FUNC_LOAD_B, 8'd0, 32'h80000000);
        push_item(FUNC_START, 8'd0, 32'h0);
        push_item(FUNC_UNUSED, 8'd0, 32'h0);
        push_item(FUNC_LOAD_L, 8'd136, 32'h1234_5678);
        push_item(FUNC_LOAD_L, 8'd255, 32'hffffffff);
        push_item(FUNC_LOAD_B, 8'd16, 32'h5555_aaaa);
        push_item(FUNC_LOAD_L, 8'd0, 32'hffff_0000);
        push_item(FUNC_START, 8'd0, 32'h0);
        wait_drained();

        // pause the sender with a backlog queued, then release it
        hold_sender = 1'b1;
        write_dimension(5'd2);
        queue_solve();
        repeat (30) @(posedge aclk);
        hold_sender = 1'b0;
        wait_drained();

        // random phases over several dimensions, extremes included
        dims = '{5'd31, 5'd0, 5'd16, 5'd3, 5'd1, 5'd5, 5'd4};
        phase = 0;
        while (stim_count < 400) begin
            if (phase < dims.size()) write_dimension(dims[phase]);
            else write_dimension(5'($urandom_range(2, 8)));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ((eff_dim() > 8) ? 1 : $urandom_range(2, 5)) queue_solve();
            wait_drained();
            phase++;
        end

        repeat (100) @(posedge aclk);
        $display("Ran %0d solves over %0d dimension phases; %0d results checked.",
                 solves_run, phase + 2, results_seen);
        $display("Runs with zero pivot: %0d, with saturation: %0d.", pivot_runs, sat_runs);
        if (fail_count == 0 && solution_q.size() == 0) begin
            $display("** packed_cholesky_solve: PASSED **");
        end else begin
            $display("** packed_cholesky_solve: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pcs_pkg.sv
rtl/pcs_ram.sv
rtl/packed_cholesky_solve.sv
bench/packed_cholesky_solve_tb.sv
